// ----- rtl/core/trs_model_matrix_builder_assert.svh -----
// assertion macros shared by the checker of the matrix builder
`ifndef TRS_MODEL_MATRIX_BUILDER_ASSERT_SVH
`define TRS_MODEL_MATRIX_BUILDER_ASSERT_SVH

// concurrent check on clk, held off while rst is high
`define TRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("trs check failed");

// same check, stated as an implication from a trigger
`define TRS_ASSERT_IMP(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("trs check failed");

`endif

// ----- rtl/core/trs_pkg.sv -----
// shared types, constants and helpers of the trs model matrix builder
package trs_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int WIDE_W        = 66;
  localparam int FRAC_BITS_DEF = 16;

  // row numbers of the emitted matrix
  localparam logic [1:0] FIRST_ROW_IDX = 2'd0;
  localparam logic [1:0] LAST_ROW_IDX  = 2'd3;

  // busy window after each accepted transaction
  localparam logic [1:0] GAP_CYCLES = 2'd3;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

  // one input transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] translate_x;
    logic signed [DATA_W-1:0] translate_y;
    logic signed [DATA_W-1:0] translate_z;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] scale_x;
    logic signed [DATA_W-1:0] scale_y;
    logic signed [DATA_W-1:0] scale_z;
  } item_t;

  // quaternion products plus pass-through vectors
  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] xw;
    logic signed [PROD_W-1:0] yw;
    logic signed [PROD_W-1:0] zw;
    logic [2:0][DATA_W-1:0]   translate;
    logic [2:0][DATA_W-1:0]   scale;
  } prod_t;

  // saturated rotation matrix plus pass-through vectors
  typedef struct packed {
    logic [2:0][2:0][DATA_W-1:0] r;
    logic [2:0][2:0]             ovf;
    logic [2:0][DATA_W-1:0]      translate;
    logic [2:0][DATA_W-1:0]      scale;
  } rot_t;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // clamp a wide signed value to 32 bits and flag the clamp
  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    if (x > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = SAT_MIN[DATA_W-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/trs_quat_prod.sv -----
// input register and quaternion product stage
module trs_quat_prod
  import trs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t item,
  output logic  prod_valid,
  output prod_t prod
);

  logic  a_valid;
  item_t a_item;

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    if (in_valid) begin
      a_item <= item;
    end
  end

  // nine full-width products, one multiplier each
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= a_valid;
    end
    if (a_valid) begin
      prod.xx <= 64'(a_item.quat_x) * 64'(a_item.quat_x);
      prod.yy <= 64'(a_item.quat_y) * 64'(a_item.quat_y);
      prod.zz <= 64'(a_item.quat_z) * 64'(a_item.quat_z);
      prod.xy <= 64'(a_item.quat_x) * 64'(a_item.quat_y);
      prod.xz <= 64'(a_item.quat_x) * 64'(a_item.quat_z);
      prod.yz <= 64'(a_item.quat_y) * 64'(a_item.quat_z);
      prod.xw <= 64'(a_item.quat_x) * 64'(a_item.quat_w);
      prod.yw <= 64'(a_item.quat_y) * 64'(a_item.quat_w);
      prod.zw <= 64'(a_item.quat_z) * 64'(a_item.quat_w);
      prod.translate <= {a_item.translate_z, a_item.translate_y, a_item.translate_x};
      prod.scale     <= {a_item.scale_z, a_item.scale_y, a_item.scale_x};
    end
  end

endmodule

// ----- rtl/core/trs_rot_entry.sv -----
// rotation matrix entries from quaternion products, saturated to 32 bits
module trs_rot_entry
  import trs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  prod_valid,
  input  prod_t prod,
  output logic  rot_valid,
  output rot_t  rot
);

  localparam logic [PROD_W:0] RND =
    (65'(1) << (FRAC_BITS - 1)) - 65'(1);
  localparam logic signed [WIDE_W-1:0] ONE_W = 66'sd1 <<< FRAC_BITS;

  // 1 - 2(p + q), floored to FRAC_BITS fraction bits
  function automatic logic signed [WIDE_W-1:0] rot_diag(
    input logic signed [PROD_W-1:0] p,
    input logic signed [PROD_W-1:0] q
  );
    logic [PROD_W:0] u;
    logic [PROD_W:0] c;
    u = {1'b0, p} + {1'b0, q};
    c = (u + RND) >> (FRAC_BITS - 1);
    return ONE_W - $signed({1'b0, c});
  endfunction

  // 2(a + b) or 2(a - b), floored to FRAC_BITS fraction bits
  function automatic logic signed [WIDE_W-1:0] rot_off(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b,
    input logic                     neg
  );
    logic signed [WIDE_W-1:0] sa;
    logic signed [WIDE_W-1:0] sb;
    logic signed [WIDE_W-1:0] sum;
    sa  = 66'(a);
    sb  = 66'(b);
    sum = neg ? (sa - sb) : (sa + sb);
    return sum >>> (FRAC_BITS - 1);
  endfunction

  sat_t ent [3][3];

  // entry formation and clamp
  always_comb begin
    ent[0][0] = sat32(rot_diag(prod.yy, prod.zz));
    ent[0][1] = sat32(rot_off(prod.xy, prod.zw, 1'b1));
    ent[0][2] = sat32(rot_off(prod.xz, prod.yw, 1'b0));
    ent[1][0] = sat32(rot_off(prod.xy, prod.zw, 1'b0));
    ent[1][1] = sat32(rot_diag(prod.xx, prod.zz));
    ent[1][2] = sat32(rot_off(prod.yz, prod.xw, 1'b1));
    ent[2][0] = sat32(rot_off(prod.xz, prod.yw, 1'b1));
    ent[2][1] = sat32(rot_off(prod.yz, prod.xw, 1'b0));
    ent[2][2] = sat32(rot_diag(prod.xx, prod.yy));
  end

  // rotation register, held until the next transaction arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else begin
      rot_valid <= prod_valid;
    end
    if (prod_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot.r[i][j]   <= ent[i][j].val;
          rot.ovf[i][j] <= ent[i][j].ovf;
        end
      end
      rot.translate <= prod.translate;
      rot.scale     <= prod.scale;
    end
  end

endmodule

// ----- rtl/core/trs_row_seq.sv -----
// row sequencer: scales one rotation row per cycle and drives the result ports
module trs_row_seq
  import trs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rot_valid,
  input  rot_t                     rot,
  output logic                     strobe,
  output logic [1:0]               row_index,
  output logic signed [DATA_W-1:0] elem_col0,
  output logic signed [DATA_W-1:0] elem_col1,
  output logic signed [DATA_W-1:0] elem_col2,
  output logic signed [DATA_W-1:0] elem_col3,
  output logic                     row_overflow,
  output logic                     last_row
);

  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  logic                     gen_active;
  logic                     gen_active_next;
  logic [1:0]               gen_row;
  logic [1:0]               gen_row_next;
  logic                     issue_valid;
  logic [1:0]               issue_row;
  logic signed [DATA_W-1:0] rv [3];
  logic                     issue_ovf;
  logic signed [DATA_W-1:0] issue_col3;

  logic                     m_valid;
  logic [1:0]               m_row;
  logic                     m_ovf;
  logic signed [DATA_W-1:0] m_col3;
  logic signed [PROD_W-1:0] m_prod [3];

  sat_t                     fin [3];

  // row counter: row 0 issues with the transaction, rows 1 to 3 follow
  always_comb begin
    issue_valid     = rot_valid | gen_active;
    issue_row       = rot_valid ? FIRST_ROW_IDX : gen_row;
    gen_active_next = gen_active;
    gen_row_next    = gen_row;
    if (rot_valid) begin
      gen_active_next = 1'b1;
      gen_row_next    = 2'(FIRST_ROW_IDX + 2'd1);
    end else if (gen_active) begin
      gen_row_next = 2'(gen_row + 2'd1);
      if (gen_row == LAST_ROW_IDX) begin
        gen_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_active <= 1'b0;
      gen_row    <= FIRST_ROW_IDX;
    end else begin
      gen_active <= gen_active_next;
      gen_row    <= gen_row_next;
    end
  end

  // pick the rotation row, translation and flags for the issued row
  always_comb begin
    case (issue_row)
      2'd0: begin
        for (int j = 0; j < 3; j++) rv[j] = $signed(rot.r[0][j]);
        issue_ovf  = |rot.ovf[0];
        issue_col3 = $signed(rot.translate[0]);
      end
      2'd1: begin
        for (int j = 0; j < 3; j++) rv[j] = $signed(rot.r[1][j]);
        issue_ovf  = |rot.ovf[1];
        issue_col3 = $signed(rot.translate[1]);
      end
      2'd2: begin
        for (int j = 0; j < 3; j++) rv[j] = $signed(rot.r[2][j]);
        issue_ovf  = |rot.ovf[2];
        issue_col3 = $signed(rot.translate[2]);
      end
      default: begin
        for (int j = 0; j < 3; j++) rv[j] = '0;
        issue_ovf  = 1'b0;
        issue_col3 = ONE_Q;
      end
    endcase
  end

  // scale products, one multiplier per column
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= issue_valid;
    end
    if (issue_valid) begin
      for (int j = 0; j < 3; j++) begin
        m_prod[j] <= 64'(rv[j]) * 64'($signed(rot.scale[j]));
      end
      m_row  <= issue_row;
      m_ovf  <= issue_ovf;
      m_col3 <= issue_col3;
    end
  end

  // back to FRAC_BITS fraction bits and clamp
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fin[j] = sat32(66'(m_prod[j] >>> FRAC_BITS));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= m_valid;
    end
    if (m_valid) begin
      row_index    <= m_row;
      elem_col0    <= fin[0].val;
      elem_col1    <= fin[1].val;
      elem_col2    <= fin[2].val;
      elem_col3    <= m_col3;
      row_overflow <= m_ovf | fin[0].ovf | fin[1].ovf | fin[2].ovf;
      last_row     <= (m_row == LAST_ROW_IDX);
    end
  end

endmodule

// ----- rtl/core/trs_model_matrix_builder.sv -----
// Builds the 4x4 T*R*S model matrix from translation, quaternion and scale.
// Row 0 passes the input, product, rotation, scale-product and result registers, in
// that order, before it reaches the result ports.
// Rows 0 to 3 follow back to back, the receiver never stalls; a new transaction is
// taken only once busy falls, one row per cycle on the result port.
// Reset (rst, synchronous) clears all valid bits and the busy counter; busy is high in reset.
module trs_model_matrix_builder
  import trs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] translate_x,
  input  logic signed [DATA_W-1:0] translate_y,
  input  logic signed [DATA_W-1:0] translate_z,
  input  logic signed [DATA_W-1:0] quat_x,
  input  logic signed [DATA_W-1:0] quat_y,
  input  logic signed [DATA_W-1:0] quat_z,
  input  logic signed [DATA_W-1:0] quat_w,
  input  logic signed [DATA_W-1:0] scale_x,
  input  logic signed [DATA_W-1:0] scale_y,
  input  logic signed [DATA_W-1:0] scale_z,
  output logic                     strobe,
  output logic [1:0]               row_index,
  output logic signed [DATA_W-1:0] elem_col0,
  output logic signed [DATA_W-1:0] elem_col1,
  output logic signed [DATA_W-1:0] elem_col2,
  output logic signed [DATA_W-1:0] elem_col3,
  output logic                     row_overflow,
  output logic                     last_row
);

  logic       accept;
  logic [1:0] gap;
  logic [1:0] gap_next;
  item_t      item;
  logic       prod_valid;
  prod_t      prod;
  logic       rot_valid;
  rot_t       rot;

  assign accept = start & ~busy;
  assign busy   = rst | (gap != 2'd0);

  // busy window after each transaction keeps the result port free
  always_comb begin
    gap_next = gap;
    if (accept) begin
      gap_next = GAP_CYCLES;
    end else if (gap != 2'd0) begin
      gap_next = 2'(gap - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else begin
      gap <= gap_next;
    end
  end

  // gather the transaction fields
  always_comb begin
    item.translate_x = translate_x;
    item.translate_y = translate_y;
    item.translate_z = translate_z;
    item.quat_x      = quat_x;
    item.quat_y      = quat_y;
    item.quat_z      = quat_z;
    item.quat_w      = quat_w;
    item.scale_x     = scale_x;
    item.scale_y     = scale_y;
    item.scale_z     = scale_z;
  end

  trs_quat_prod u_prod (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .item       (item),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  trs_rot_entry #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rot (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .rot_valid  (rot_valid),
    .rot        (rot)
  );

  trs_row_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .rot_valid    (rot_valid),
    .rot          (rot),
    .strobe       (strobe),
    .row_index    (row_index),
    .elem_col0    (elem_col0),
    .elem_col1    (elem_col1),
    .elem_col2    (elem_col2),
    .elem_col3    (elem_col3),
    .row_overflow (row_overflow),
    .last_row     (last_row)
  );

endmodule

// ----- rtl/core/trs_checker.sv -----
// port-level checks of the matrix builder, bound to the top level
`include "trs_model_matrix_builder_assert.svh"

module trs_checker
  import trs_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     strobe,
  input logic [1:0]               row_index,
  input logic signed [DATA_W-1:0] elem_col0,
  input logic signed [DATA_W-1:0] elem_col1,
  input logic signed [DATA_W-1:0] elem_col2,
  input logic                     row_overflow,
  input logic                     last_row
);

  // an accepted transaction closes the input until its rows are under way
  `TRS_ASSERT(a_busy_after_accept, (start && !busy) |=> busy)

  // row 0 appears a fixed time after the accept
  `TRS_ASSERT(a_first_row_latency, (start && !busy) |-> ##5 (strobe && row_index == FIRST_ROW_IDX))

  // rows of one transaction come back to back in order
  `TRS_ASSERT_IMP(a_rows_in_order, strobe && row_index != LAST_ROW_IDX, ##1 (strobe && row_index == 2'($past(row_index) + 2'd1)))

  // the last row is the fixed bottom row
  `TRS_ASSERT_IMP(a_last_row_const, strobe && last_row, row_index == LAST_ROW_IDX && elem_col0 == '0 && elem_col1 == '0 && elem_col2 == '0 && !row_overflow)

endmodule

bind trs_model_matrix_builder trs_checker u_trs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .row_index    (row_index),
  .elem_col0    (elem_col0),
  .elem_col1    (elem_col1),
  .elem_col2    (elem_col2),
  .row_overflow (row_overflow),
  .last_row     (last_row)
);

// ----- dv/tb.sv -----
// self-checking testbench of the trs model matrix builder
`timescale 1ns / 100ps

module tb;
  import trs_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int RANDOM_PER_PHASE = 114;
  localparam int MAX_GAP = 20;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_BOT = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_BIG = 32'sh0100_0000;

  typedef logic signed [127:0] wide_t;
  localparam wide_t WIDE_TOP = 128'sd2147483647;
  localparam wide_t WIDE_BOT = -128'sd2147483648;

  // one matrix row as seen on the result ports
  typedef struct packed {
    logic [1:0]              index;
    logic [3:0][DATA_W-1:0]  col;
    logic                    ovf;
    logic                    last;
  } row_t;

  // directed stimulus entry; typed entries expect a diagonal rotation block
  typedef struct packed {
    item_t                   it;
    logic                    typed;
    logic [2:0][DATA_W-1:0]  diag;
    logic [2:0]              ovf;
  } vector_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [DATA_W-1:0] translate_x = '0;
  logic signed [DATA_W-1:0] translate_y = '0;
  logic signed [DATA_W-1:0] translate_z = '0;
  logic signed [DATA_W-1:0] quat_x = '0;
  logic signed [DATA_W-1:0] quat_y = '0;
  logic signed [DATA_W-1:0] quat_z = '0;
  logic signed [DATA_W-1:0] quat_w = '0;
  logic signed [DATA_W-1:0] scale_x = '0;
  logic signed [DATA_W-1:0] scale_y = '0;
  logic signed [DATA_W-1:0] scale_z = '0;
  logic busy;
  logic strobe;
  logic [1:0] row_index;
  logic signed [DATA_W-1:0] elem_col0;
  logic signed [DATA_W-1:0] elem_col1;
  logic signed [DATA_W-1:0] elem_col2;
  logic signed [DATA_W-1:0] elem_col3;
  logic row_overflow;
  logic last_row;

  row_t    rows_due [$];
  vector_t directed [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;

  trs_model_matrix_builder dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .translate_x  (translate_x),
    .translate_y  (translate_y),
    .translate_z  (translate_z),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z),
    .quat_w       (quat_w),
    .scale_x      (scale_x),
    .scale_y      (scale_y),
    .scale_z      (scale_z),
    .strobe       (strobe),
    .row_index    (row_index),
    .elem_col0    (elem_col0),
    .elem_col1    (elem_col1),
    .elem_col2    (elem_col2),
    .elem_col3    (elem_col3),
    .row_overflow (row_overflow),
    .last_row     (last_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp to 32 bits, raising the flag on a clamp
  function automatic logic signed [DATA_W-1:0] clamp_q(input wide_t v, inout logic flag);
    if (v > WIDE_TOP) begin
      flag = 1'b1;
      return Q_TOP;
    end
    if (v < WIDE_BOT) begin
      flag = 1'b1;
      return Q_BOT;
    end
    return v[DATA_W-1:0];
  endfunction

  // floor of (1 - 2(p + q)) at FB fraction bits
  function automatic wide_t diag_entry(input wide_t p, input wide_t q);
    return ((wide_t'(1) <<< (2 * FB)) - 2 * (p + q)) >>> FB;
  endfunction

  // floor of 2(a + b), or 2(a - b), at FB fraction bits
  function automatic wide_t cross_entry(input wide_t a, input wide_t b, input bit minus);
    return (2 * (minus ? a - b : a + b)) >>> FB;
  endfunction

  // rotation times scale block of the model matrix, with per-row saturation flags
  function automatic void predict_matrix(input item_t it,
                                         output logic [2:0][2:0][DATA_W-1:0] ent,
                                         output logic [2:0] flags);
    wide_t x, y, z, w, xx, yy, zz, xy, xz, yz, xw, yw, zw, rv;
    wide_t rot [3][3];
    logic [2:0][DATA_W-1:0] sv;
    logic signed [DATA_W-1:0] re;
    logic flag;
    x = it.quat_x;
    y = it.quat_y;
    z = it.quat_z;
    w = it.quat_w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    xw = x * w;
    yw = y * w;
    zw = z * w;
    rot[0][0] = diag_entry(yy, zz);
    rot[0][1] = cross_entry(xy, zw, 1'b1);
    rot[0][2] = cross_entry(xz, yw, 1'b0);
    rot[1][0] = cross_entry(xy, zw, 1'b0);
    rot[1][1] = diag_entry(xx, zz);
    rot[1][2] = cross_entry(yz, xw, 1'b1);
    rot[2][0] = cross_entry(xz, yw, 1'b1);
    rot[2][1] = cross_entry(yz, xw, 1'b0);
    rot[2][2] = diag_entry(xx, yy);
    sv = {it.scale_z, it.scale_y, it.scale_x};
    for (int i = 0; i < 3; i++) begin
      flag = 1'b0;
      for (int j = 0; j < 3; j++) begin
        // rotation entry clamps first, then the scaled product clamps again
        re = clamp_q(rot[i][j], flag);
        rv = re;
        rv = rv * $signed(sv[j]);
        ent[i][j] = clamp_q(rv >>> FB, flag);
      end
      flags[i] = flag;
    end
  endfunction

  function automatic item_t mk_item(
      input logic signed [DATA_W-1:0] tx, ty, tz, qx, qy, qz, qw, sx, sy, sz);
    return {tx, ty, tz, qx, qy, qz, qw, sx, sy, sz};
  endfunction

  task automatic add_vector(input item_t it, input logic typed,
                            input logic signed [DATA_W-1:0] d0, d1, d2,
                            input logic [2:0] ovf);
    vector_t v;
    v.it = it;
    v.typed = typed;
    v.diag = {d2, d1, d0};
    v.ovf = ovf;
    directed.push_back(v);
  endtask

  // mostly values within +-span, some anything, some extremes
  function automatic logic signed [DATA_W-1:0] rand_fix(input int unsigned span);
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return Q_TOP;
          1: return Q_BOT;
          2: return '0;
          3: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      default: return $urandom_range(2 * span) - span;
    endcase
  endfunction

  function automatic vector_t random_vector();
    vector_t v;
    v = '0;
    v.it.translate_x = rand_fix(32'h4000_0000);
    v.it.translate_y = rand_fix(32'h4000_0000);
    v.it.translate_z = rand_fix(32'h4000_0000);
    v.it.quat_x = rand_fix(Q_ONE);
    v.it.quat_y = rand_fix(Q_ONE);
    v.it.quat_z = rand_fix(Q_ONE);
    v.it.quat_w = rand_fix(Q_ONE);
    v.it.scale_x = rand_fix(16 * Q_ONE);
    v.it.scale_y = rand_fix(16 * Q_ONE);
    v.it.scale_z = rand_fix(16 * Q_ONE);
    return v;
  endfunction

  function automatic int draw_gap(input int pct);
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // drive one transaction, wait for its accept, then queue the four expected rows
  task automatic push_transform(input vector_t v, input int gap);
    logic [2:0][2:0][DATA_W-1:0] ent;
    logic [2:0] flags;
    logic [2:0][DATA_W-1:0] tv;
    row_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {translate_x, translate_y, translate_z, quat_x, quat_y, quat_z, quat_w,
     scale_x, scale_y, scale_z} <= v.it;
    do @(posedge clk); while (busy);
    if (v.typed) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          ent[i][j] = (i == j) ? v.diag[i] : '0;
      flags = v.ovf;
    end else begin
      predict_matrix(v.it, ent, flags);
    end
    tv = {v.it.translate_z, v.it.translate_y, v.it.translate_x};
    for (int i = 0; i < 4; i++) begin
      r.index = 2'(i);
      r.last = (r.index == LAST_ROW_IDX);
      if (r.last) begin
        r.col = {Q_ONE, 32'd0, 32'd0, 32'd0};
        r.ovf = 1'b0;
      end else begin
        r.col = {tv[i], ent[i][2], ent[i][1], ent[i][0]};
        r.ovf = flags[i];
      end
      rows_due.push_back(r);
    end
  endtask

  // hold off new transactions until every queued row has come out
  task automatic wait_matrix_drained();
    start <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
  endtask

  function automatic string row_text(input row_t r);
    return $sformatf("row %0d cols %0d %0d %0d %0d ovf %0b last %0b", r.index,
                     $signed(r.col[0]), $signed(r.col[1]), $signed(r.col[2]),
                     $signed(r.col[3]), r.ovf, r.last);
  endfunction

  task automatic note_mismatch(input string text);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", text);
  endtask

  // result checker
  always @(posedge clk) begin
    row_t got, want;
    if (!rst && strobe) begin
      got.index = row_index;
      got.col = {elem_col3, elem_col2, elem_col1, elem_col0};
      got.ovf = row_overflow;
      got.last = last_row;
      if (rows_due.size() == 0) begin
        note_mismatch({"unexpected result: ", row_text(got)});
      end else begin
        want = rows_due.pop_front();
        if (got.index !== want.index || got.col[0] !== want.col[0] ||
            got.col[1] !== want.col[1] || got.col[2] !== want.col[2] ||
            got.col[3] !== want.col[3] || got.ovf !== want.ovf ||
            got.last !== want.last)
          note_mismatch({"mismatch: expected ", row_text(want), " got ", row_text(got)});
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int sender_pct [4];
    sender_pct = '{0, 74, 0, 38};

    // directed cases with diagonal results that can be read off directly
    add_vector(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0, 0, 3'b000);
    add_vector(mk_item(Q_ONE, -Q_ONE, 3 * Q_ONE, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE),
               1'b1, Q_ONE, Q_ONE, Q_ONE, 3'b000);
    add_vector(mk_item(Q_TOP, Q_BOT, 0, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE),
               1'b1, Q_ONE, Q_ONE, Q_ONE, 3'b000);
    add_vector(mk_item(Q_BOT, Q_TOP, -1, 0, 0, 0, Q_ONE, Q_TOP, Q_BOT, -Q_ONE),
               1'b1, Q_TOP, Q_BOT, -Q_ONE, 3'b000);
    // huge x component: rotation diagonal saturates low on rows 1 and 2
    add_vector(mk_item(5, 6, 7, Q_BIG, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE),
               1'b1, Q_ONE, Q_BOT, Q_BOT, 3'b110);
    // scalar part alone never reaches the diagonal
    add_vector(mk_item(0, 0, 0, 0, 0, 0, Q_BOT, Q_ONE, Q_ONE, Q_ONE),
               1'b1, Q_ONE, Q_ONE, Q_ONE, 3'b000);
    // remaining directed cases go through the predictor
    add_vector(mk_item(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP),
               1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT),
               1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(0, 0, 0, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_TOP, Q_TOP, Q_TOP),
               1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(Q_ONE, 2 * Q_ONE, -Q_ONE, 0, 0, 46341, 46341, Q_ONE, Q_ONE, Q_ONE),
               1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(0, 0, 0, 32768, 32768, 32768, 32768, 2 * Q_ONE, -3 * Q_ONE, 16384),
               1'b0, 0, 0, 0, 3'b000);
    // half turn about x with scale pushing the product out of range
    add_vector(mk_item(-5, 0, 5, Q_ONE, 0, 0, 0, Q_ONE, Q_BOT, Q_TOP),
               1'b0, 0, 0, 0, 3'b000);
    // tiny odd values exercise the floor rounding
    add_vector(mk_item(1, -1, 0, 1, -1, 3, -3, 32'sh0001_2345, -1, 1),
               1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(1, -1, 0, -1, 1, -3, 3, -32'sh0001_2345, 1, -1),
               1'b0, 0, 0, 0, 3'b000);
    // off-diagonal saturation
    add_vector(mk_item(1, -1, 0, Q_BIG, Q_BIG, 0, Q_BIG, -Q_ONE, 32768, 3),
               1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                       32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                       32'sh5555_5555, 32'shAAAA_AAAA), 1'b0, 0, 0, 0, 3'b000);
    add_vector(mk_item(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                       32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                       32'shAAAA_AAAA, 32'sh5555_5555), 1'b0, 0, 0, 0, 3'b000);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) push_transform(directed[k], 0);
    wait_matrix_drained();

    // random phases, draining between them
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        push_transform(random_vector(), draw_gap(sender_pct[phase]));
      if (phase < 3) wait_matrix_drained();
    end

    start <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rows_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
